FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file pfd_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, ignored while reset is asserted.
`define PFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, including while reset is asserted.
`define PFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pfd_pkg.sv
`default_nettype none
package pfd_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned PAYLOAD_BYTES_DEF = 24;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h0D;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h0A;
  localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'h0A;
  localparam logic [BYTE_W-1:0] TRL_SECOND = 8'h0D;
  localparam logic [WORD_W-1:0] SIGN_BIT   = 32'h8000_0000;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR2 = 5'b00010,
    PH_DATA = 5'b00100,
    PH_TRL1 = 5'b01000,
    PH_TRL2 = 5'b10000
  } phase_t;

  typedef struct packed {
    logic shift;
    logic emit;
  } pfd_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/pfd_if.sv
`default_nettype none
interface pfd_in_if;
  logic                       valid;
  logic                       ready;
  logic [pfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfd_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfd_pkg::WORD_W-1:0] heading_bits;
  logic [pfd_pkg::WORD_W-1:0] forward_bits;
  logic [pfd_pkg::WORD_W-1:0] left_bits;

  modport source (output valid, output heading_bits, output forward_bits,
                  output left_bits, input ready);
  modport sink (input valid, input heading_bits, input forward_bits,
                input left_bits, output ready);
endinterface
`default_nettype wire

FILE: rtl/pfd_cell.sv
`default_nettype none
module pfd_cell (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic [pfd_pkg::BYTE_W-1:0] data_in,
  output logic      [pfd_pkg::BYTE_W-1:0] data_out
);

  logic [pfd_pkg::BYTE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= data_in;
    end
  end

  assign data_out = data_r;

endmodule
`default_nettype wire

FILE: rtl/pfd_ctrl.sv
`default_nettype none
module pfd_ctrl #(
  parameter int unsigned PAYLOAD_BYTES = pfd_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [pfd_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                       out_full,
  output logic                            in_ready,
  output pfd_pkg::pfd_ctrl_t              ctl
);

  localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

  pfd_pkg::phase_t phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             acc;

  always_comb begin
    in_ready  = !((phase_r == pfd_pkg::PH_TRL2) && out_full);
    acc       = in_valid && in_ready;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    ctl.shift = 1'b0;
    ctl.emit  = 1'b0;
    if (acc) begin
      unique case (phase_r)
        pfd_pkg::PH_IDLE: begin
          phase_nxt = (rx_byte == pfd_pkg::HDR_FIRST) ? pfd_pkg::PH_HDR2 : pfd_pkg::PH_IDLE;
        end
        pfd_pkg::PH_HDR2: begin
          if (rx_byte == pfd_pkg::HDR_SECOND) begin
            idx_nxt   = '0;
            phase_nxt = pfd_pkg::PH_DATA;
          end else if (rx_byte != pfd_pkg::HDR_FIRST) begin
            phase_nxt = pfd_pkg::PH_IDLE;
          end
        end
        pfd_pkg::PH_DATA: begin
          ctl.shift = 1'b1;
          if (idx_r == IDX_LAST) begin
            idx_nxt   = '0;
            phase_nxt = pfd_pkg::PH_TRL1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        pfd_pkg::PH_TRL1: begin
          phase_nxt = (rx_byte == pfd_pkg::TRL_FIRST) ? pfd_pkg::PH_TRL2 : pfd_pkg::PH_IDLE;
        end
        pfd_pkg::PH_TRL2: begin
          ctl.emit  = (rx_byte == pfd_pkg::TRL_SECOND);
          phase_nxt = pfd_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = pfd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pfd_pkg::PH_IDLE;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pose_frame_deframer_top.sv
// A result is registered on the transfer of the final trailer byte and presented in the next cycle.
// Throughput: one byte per cycle when not stalled, with a result held in the output register meanwhile.
// Input stalls only when the last trailer byte arrives while an earlier result is untaken.
// Reset (synchronous, active low) clears the parser phase, the byte counter and output valid.
// The payload shift cells are not reset; every cell is refilled before a frame completes.
`default_nettype none
module pose_frame_deframer_top #(
  parameter int unsigned PAYLOAD_BYTES = pfd_pkg::PAYLOAD_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pfd_in_if.sink    in_ch,
  pfd_out_if.source out_ch
);

  localparam int unsigned W0_BASE = PAYLOAD_BYTES - 4;
  localparam int unsigned W3_BASE = PAYLOAD_BYTES - 16;
  localparam int unsigned W4_BASE = PAYLOAD_BYTES - 20;

  pfd_pkg::pfd_ctrl_t         ctl;
  logic                       out_valid_r;
  logic [pfd_pkg::WORD_W-1:0] heading_r;
  logic [pfd_pkg::WORD_W-1:0] forward_r;
  logic [pfd_pkg::WORD_W-1:0] left_r;
  logic [pfd_pkg::BYTE_W-1:0] cell_q [PAYLOAD_BYTES];
  logic [pfd_pkg::WORD_W-1:0] word0, word3, word4;

  pfd_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .rx_byte  (in_ch.rx_byte),
    .out_full (out_valid_r && !out_ch.ready),
    .in_ready (in_ch.ready),
    .ctl      (ctl)
  );

  // The newest payload byte enters cell 0, so payload byte k ends in the last cell minus k.
  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      pfd_cell u_cell (
        .clk      (clk),
        .shift    (ctl.shift),
        .data_in  (in_ch.rx_byte),
        .data_out (cell_q[i])
      );
    end else begin : g_body
      pfd_cell u_cell (
        .clk      (clk),
        .shift    (ctl.shift),
        .data_in  (cell_q[i-1]),
        .data_out (cell_q[i])
      );
    end
  end

  assign word0 = {cell_q[W0_BASE], cell_q[W0_BASE+1], cell_q[W0_BASE+2], cell_q[W0_BASE+3]};
  assign word3 = {cell_q[W3_BASE], cell_q[W3_BASE+1], cell_q[W3_BASE+2], cell_q[W3_BASE+3]};
  assign word4 = {cell_q[W4_BASE], cell_q[W4_BASE+1], cell_q[W4_BASE+2], cell_q[W4_BASE+3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      heading_r <= word0;
      forward_r <= word4;
      left_r    <= word3 ^ pfd_pkg::SIGN_BIT;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.heading_bits = heading_r;
  assign out_ch.forward_bits = forward_r;
  assign out_ch.left_bits    = left_r;

endmodule
`default_nettype wire

FILE: rtl/pfd_chk.sv
`default_nettype none
`include "assert_macros.svh"
module pfd_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [pfd_pkg::BYTE_W-1:0] in_rx_byte,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [pfd_pkg::WORD_W-1:0] out_heading_bits
);

  logic stalled;
  logic trl_end;

  assign stalled = out_valid && !out_ready;
  assign trl_end = in_valid && in_ready && (in_rx_byte == pfd_pkg::TRL_SECOND);

  `PFD_ASSERT_ALWAYS(a_reset_clears_valid, !rst_n |=> !out_valid, "result valid after reset")
  `PFD_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no result held")
  `PFD_ASSERT(a_after_trailer, out_valid && !$past(stalled) |-> $past(trl_end), "stray result")
  `PFD_ASSERT(a_hold, $past(stalled) |-> out_valid && $stable(out_heading_bits), "result changed")

endmodule

bind pose_frame_deframer_top pfd_chk u_pfd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_rx_byte       (in_ch.rx_byte),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_heading_bits (out_ch.heading_bits)
);
`default_nettype wire
